[design/argmax_with_tie_pick_assert.svh]
// assertion macros shared by the argmax tie-pick checker
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ARGMAX_WITH_TIE_PICK_ASSERT_SVH
`define ARGMAX_WITH_TIE_PICK_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define AWTP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define AWTP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/awtp_pkg.sv]
// shared widths and register indexes for the argmax tie-pick block
// no dependencies; used by the top level and the port checker
package awtp_pkg;

   // field widths
   localparam int PROB_W = 17;
   localparam int DRAW_W = 16;
   localparam int OUT_W  = 7;

   // packed bus widths (whole bytes)
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 16;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PROB = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIE_TOL  = 1'd1;

   // register reset values
   localparam logic [PROB_W-1:0] MIN_PROB_RST = 17'd0;
   localparam logic [PROB_W-1:0] TIE_TOL_RST  = 17'd1;

endpackage

[design/awtp_tie_list.sv]
// tie list storage: one write port, one registered read port
// no package dependency; instantiated by argmax_with_tie_pick
module awtp_tie_list #(
   parameter int DEPTH = 64,
   parameter int DW    = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/argmax_with_tie_pick.sv]
// argmax with tolerance ties and a random pick among the tied entries
// depends on awtp_pkg and awtp_tie_list
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: prob, random_draw; tlast: last
//   rsp      out  rsp_tvalid/tready     tdata: chosen_state, tie_count
//   csr      in   csr_wr_en             csr_index, csr_wdata
//
// one item per cycle unless a last item waits; a result is registered once its last item leaves the input register
// the running max / tie count update is combinational from the input register
// req_tready drops only while a last item waits for a full result register
// reset clears control state and loads min_prob = 0, tie_tolerance = 1
// the tie list holds no reset value: only entries of the current group are read
module argmax_with_tie_pick
   import awtp_pkg::*;
#(
   parameter int MAX_GEN = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // prob [16:0], random_draw [32:17], zero [39:33]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tlast,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // chosen_state [6:0], tie_count [13:7], zero [15:14]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(MAX_GEN + 1);
   localparam int AW = $clog2(MAX_GEN);
   localparam logic [IW-1:0] GEN_LIMIT = IW'(MAX_GEN);
   localparam logic [IW-1:0] ONE_IDX   = IW'(1);

   // configuration registers
   logic [PROB_W-1:0] min_prob_ff;
   logic [PROB_W-1:0] tie_tol_ff;

   // input register
   logic              s1_valid_ff;
   logic [PROB_W-1:0] s1_prob_ff;
   logic [DRAW_W-1:0] s1_draw_ff;
   logic              s1_last_ff;

   // group state
   logic [PROB_W-1:0] run_max_ff, run_max_in;
   logic [IW-1:0]     elem_idx_ff, elem_idx_in;
   logic [IW-1:0]     tie_total_ff, tie_total_in;

   // result register
   logic              rsp_valid_ff;
   logic [IW-1:0]     cnt_ff;
   logic              byp_ff;
   logic [IW-1:0]     byp_data_ff;

   logic              s1_go;
   logic [PROB_W-1:0] cur_max;
   logic              active;
   logic [IW-1:0]     pos;
   logic [PROB_W-1:0] diff;
   logic              is_tie;
   logic              is_new;
   logic              append;
   logic [IW-1:0]     total_nx;
   logic [DRAW_W+IW-1:0] prod;
   logic [AW-1:0]     pick;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic              rd_en;
   logic [IW-1:0]     rd_data;
   logic [IW-1:0]     chosen;

   // handshake: a last item moves on only when the result register frees
   assign s1_go      = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_prob_ff <= MIN_PROB_RST;
         tie_tol_ff  <= TIE_TOL_RST;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_MIN_PROB) begin
            min_prob_ff <= csr_wdata;
         end
         if (csr_index == CSR_TIE_TOL) begin
            tie_tol_ff <= csr_wdata;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_prob_ff <= req_tdata[PROB_W-1:0];
         s1_draw_ff <= req_tdata[PROB_W +: DRAW_W];
         s1_last_ff <= req_tlast;
      end
   end

   // compare against the running max, reloaded at group start
   always_comb begin
      cur_max = (elem_idx_ff == '0) ? min_prob_ff : run_max_ff;
      active  = elem_idx_ff < GEN_LIMIT;
      pos     = elem_idx_ff + ONE_IDX;
      diff    = (s1_prob_ff >= cur_max) ? (s1_prob_ff - cur_max) : (cur_max - s1_prob_ff);
      is_tie  = active && (diff < tie_tol_ff);
      is_new  = active && !is_tie && (s1_prob_ff > cur_max);
      append  = is_tie && (tie_total_ff < GEN_LIMIT);
   end

   // next group state
   always_comb begin
      total_nx = tie_total_ff;
      if (append) begin
         total_nx = tie_total_ff + ONE_IDX;
      end else if (is_new) begin
         total_nx = ONE_IDX;
      end
      run_max_in   = is_new ? s1_prob_ff : cur_max;
      elem_idx_in  = active ? pos : elem_idx_ff;
      tie_total_in = total_nx;
      if (s1_last_ff) begin
         elem_idx_in  = '0;
         tie_total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_idx_ff  <= '0;
         tie_total_ff <= '0;
      end else if (s1_go) begin
         elem_idx_ff  <= elem_idx_in;
         tie_total_ff <= tie_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         run_max_ff <= run_max_in;
      end
   end

   // tie list write and random pick
   assign wr_en   = s1_go && (append || is_new);
   assign wr_addr = is_new ? '0 : tie_total_ff[AW-1:0];
   assign prod    = {{IW{1'b0}}, s1_draw_ff} * {{DRAW_W{1'b0}}, total_nx};
   assign pick    = prod[DRAW_W +: AW];
   assign rd_en   = s1_go && s1_last_ff;

   awtp_tie_list #(
      .DEPTH (MAX_GEN),
      .DW    (IW)
   ) u_tie_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (pos),
      .rd_en   (rd_en),
      .rd_addr (pick),
      .rd_data (rd_data)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // the picked entry may be the one written with the same item
   always_ff @(posedge clock) begin
      if (rd_en) begin
         cnt_ff      <= total_nx;
         byp_ff      <= wr_en && (wr_addr == pick);
         byp_data_ff <= pos;
      end
   end

   always_comb begin
      chosen = byp_ff ? byp_data_ff : rd_data;
      if (cnt_ff == '0) begin
         chosen = '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2*OUT_W){1'b0}}, OUT_W'(cnt_ff), OUT_W'(chosen)};

endmodule

[design/awtp_checker.sv]
// port-level checker for argmax_with_tie_pick, attached by bind
// depends on awtp_pkg and argmax_with_tie_pick_assert.svh
`include "argmax_with_tie_pick_assert.svh"

module awtp_checker
   import awtp_pkg::*;
#(
   parameter int MAX_GEN = 64
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tlast,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready
);

   localparam logic SMALL_GEN = (MAX_GEN < 128);

   logic [OUT_W-1:0] chosen_state;
   logic [OUT_W-1:0] tie_count;

   assign chosen_state = rsp_tdata[OUT_W-1:0];
   assign tie_count    = rsp_tdata[OUT_W +: OUT_W];

   // a stalled result holds
   `AWTP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // a new result follows a taken last item
   `AWTP_ASSERT_NOW(a_rsp_cause, $rose(rsp_tvalid),
      $past(req_tvalid && req_tready && req_tlast, 2), "result without a last item")

   // an empty tie list reports no choice
   `AWTP_ASSERT_NOW(a_empty_na, SMALL_GEN && rsp_tvalid && (tie_count == '0),
      chosen_state == '0, "choice given with no ties")

   // a non-empty tie list always reports a choice
   `AWTP_ASSERT_NOW(a_tie_pick, SMALL_GEN && rsp_tvalid && (tie_count != '0),
      chosen_state != '0, "no choice with ties present")

endmodule

bind argmax_with_tie_pick awtp_checker #(.MAX_GEN(MAX_GEN)) u_awtp_checker (.*);
